[sv/ita_pkg.sv]
package ita_pkg;

   // Format codes carried on req_kind; unlisted codes print as unsigned decimal.
   localparam logic [2:0] KIND_SIGNED_DEC = 3'd0;
   localparam logic [2:0] KIND_OCTAL      = 3'd2;
   localparam logic [2:0] KIND_HEX_LOWER  = 3'd3;
   localparam logic [2:0] KIND_HEX_UPPER  = 3'd4;

   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_MINUS   = 8'h2D;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_DABBLE,
      OP_TOP,
      OP_SLICE,
      OP_SKIP,
      OP_SIGN,
      OP_DIGIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_RADIX,
      C_BITS_LEFT,
      C_LEAD_ZERO,
      C_POS,
      C_MORE
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type P_IDLE   = 4'd0;
   localparam step_type P_KIND   = 4'd1;
   localparam step_type P_DABBLE = 4'd2;
   localparam step_type P_TOP    = 4'd3;
   localparam step_type P_SLICE  = 4'd4;
   localparam step_type P_SCAN   = 4'd5;
   localparam step_type P_SGNCHK = 4'd6;
   localparam step_type P_SIGN   = 4'd7;
   localparam step_type P_DIGIT  = 4'd8;
   localparam step_type P_EXIT   = 4'd9;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Conditions and hold request reported by the datapath to the sequencer.
   typedef struct packed {
      logic hold;
      logic no_req;
      logic radix;
      logic bits_left;
      logic lead_zero;
      logic pos;
      logic more;
   } status_type;

   // Control store.
   function automatic ctrl_word_type prog_word(step_type step);
      ctrl_word_type w;
      case (step)
         P_IDLE:   w = '{OP_ACCEPT, C_NO_REQ,    P_IDLE};
         P_KIND:   w = '{OP_CLEAR,  C_RADIX,     P_SLICE};
         P_DABBLE: w = '{OP_DABBLE, C_BITS_LEFT, P_DABBLE};
         P_TOP:    w = '{OP_TOP,    C_ALWAYS,    P_SCAN};
         P_SLICE:  w = '{OP_SLICE,  C_NEVER,     P_IDLE};
         P_SCAN:   w = '{OP_SKIP,   C_LEAD_ZERO, P_SCAN};
         P_SGNCHK: w = '{OP_NONE,   C_POS,       P_DIGIT};
         P_SIGN:   w = '{OP_SIGN,   C_NEVER,     P_IDLE};
         P_DIGIT:  w = '{OP_DIGIT,  C_MORE,      P_DIGIT};
         P_EXIT:   w = '{OP_NONE,   C_ALWAYS,    P_IDLE};
         default:  w = '{OP_NONE,   C_ALWAYS,    P_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = ASCII_ZERO + {4'b0000, d};
      end else begin
         c = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'b0000, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

[sv/ita_seq.sv]
module ita_seq (
   input  logic                clock,
   input  logic                reset,
   input  ita_pkg::status_type status,
   output ita_pkg::op_type     op
);
   import ita_pkg::*;

   step_type      pc_ff;
   step_type      pc_in;
   ctrl_word_type word;
   logic          taken;

   always_comb begin
      word = prog_word(pc_ff);
      op   = word.op;
      case (word.cond)
         C_NEVER:     taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_NO_REQ:    taken = status.no_req;
         C_RADIX:     taken = status.radix;
         C_BITS_LEFT: taken = status.bits_left;
         C_LEAD_ZERO: taken = status.lead_zero;
         C_POS:       taken = status.pos;
         C_MORE:      taken = status.more;
         default:     taken = 1'b0;
      endcase
      // Hold the step while a character step finds the output register full and stalled.
      if (status.hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= P_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[sv/integer_to_ascii_radix.sv]
// integer_to_ascii_radix: prints one integer as ASCII text.
//
// Request channel (req_valid / req_stall): one transaction carries req_kind
// (0 signed decimal, 2 octal, 3 lower hex, 4 upper hex, anything else
// unsigned decimal), req_value (low VALUE_WIDTH bits used) and req_count_in.
// Response channel (rsp_valid / rsp_stall): one transaction per character,
// most significant digit first, no leading zeros, a lone '0' for zero, a
// leading '-' for a negative signed value. rsp_last marks the final
// character, which carries rsp_count_out = req_count_in plus the characters
// of this number, saturating at 65535; other characters carry zero.
//
// Sequencing: one number at a time, driven by a microcoded sequencer.
// Decimal takes a shift-and-add-3 pass over all VALUE_WIDTH bits; octal
// and hex load their digits in a single slice step. A scan of the digit
// store then drops leading zeros one digit a cycle, and characters leave
// one a cycle while the response is not stalled. The first character
// appears after that pass and scan. Reset returns the sequencer to idle
// and empties the output register. A stalled response holds the
// sequencer; no character is lost.
module integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_value,
   input  logic [15:0] req_count_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last,
   output logic [15:0] rsp_count_out
);
   import ita_pkg::*;

   // Digit slots: enough for the octal form, which is never shorter than
   // the decimal one.
   localparam int NDIG    = (VALUE_WIDTH + 2) / 3;
   localparam int PTR_W   = $clog2(NDIG);
   localparam int BITS_W  = $clog2(VALUE_WIDTH + 1);
   localparam int PAD_W   = 4 * NDIG;
   localparam logic [PTR_W-1:0]  PTR_TOP = PTR_W'(NDIG - 1);
   localparam logic [BITS_W-1:0] BITS_ALL = BITS_W'(VALUE_WIDTH);

   op_type     op;
   status_type status;

   logic [2:0]             kind_ff, kind_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [15:0]            cnt_ff, cnt_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [3:0]             digit_ff [NDIG];
   logic [3:0]             digit_in [NDIG];
   logic [3:0]             adj [NDIG];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [15:0]            rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   out_free;
   logic                   emit_op;
   logic                   emit;
   logic [VALUE_WIDTH-1:0] raw;
   logic [PAD_W-1:0]       pad;
   logic [3:0]             cur_digit;
   logic [15:0]            cnt_inc;
   logic                   is_radix;
   logic                   is_upper;

   ita_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   assign req_stall = (op != OP_ACCEPT);
   assign accept    = req_valid && (op == OP_ACCEPT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_op   = (op == OP_SIGN) || (op == OP_DIGIT);
   assign emit      = emit_op && out_free;

   assign raw       = req_value[VALUE_WIDTH-1:0];
   assign pad       = PAD_W'(mag_ff);
   assign cur_digit = digit_ff[ptr_ff];
   assign cnt_inc   = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 16'd1;
   assign is_radix  = (kind_ff == KIND_OCTAL) || (kind_ff == KIND_HEX_LOWER) ||
                      (kind_ff == KIND_HEX_UPPER);
   assign is_upper  = (kind_ff == KIND_HEX_UPPER);

   always_comb begin
      status.hold      = emit_op && !out_free;
      status.no_req    = !req_valid;
      status.radix     = is_radix;
      status.bits_left = (bits_ff != BITS_W'(1));
      status.lead_zero = (cur_digit == 4'd0) && (ptr_ff != '0);
      status.pos       = !neg_ff;
      status.more      = (ptr_ff != '0);
   end

   // Datapath: operand load, digit store, scan pointer and output register.
   always_comb begin
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      ptr_in       = ptr_ff;
      digit_in     = digit_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (digit_ff[i] >= 4'd5) ? digit_ff[i] + 4'd3 : digit_ff[i];
      end

      case (op)
         OP_ACCEPT: begin
            if (accept) begin
               kind_in = req_kind;
               cnt_in  = req_count_in;
               neg_in  = (req_kind == KIND_SIGNED_DEC) && raw[VALUE_WIDTH-1];
               // Two's complement negate; the most negative value reads
               // back as its true unsigned magnitude.
               mag_in  = neg_in ? (~raw + VALUE_WIDTH'(1)) : raw;
            end
         end
         OP_CLEAR: begin
            bits_in = BITS_ALL;
            for (int i = 0; i < NDIG; i++) begin
               digit_in[i] = 4'd0;
            end
         end
         OP_DABBLE: begin
            // Add 3 to every BCD digit of five or more, then shift one bit in.
            bits_in     = bits_ff - BITS_W'(1);
            mag_in      = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            digit_in[0] = {adj[0][2:0], mag_ff[VALUE_WIDTH-1]};
            for (int i = 1; i < NDIG; i++) begin
               digit_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
         end
         OP_TOP: begin
            ptr_in = PTR_TOP;
         end
         OP_SLICE: begin
            ptr_in = PTR_TOP;
            for (int i = 0; i < NDIG; i++) begin
               if (kind_ff == KIND_OCTAL) begin
                  digit_in[i] = {1'b0, pad[3*i +: 3]};
               end else begin
                  digit_in[i] = pad[4*i +: 4];
               end
            end
         end
         OP_SKIP: begin
            if (status.lead_zero) begin
               ptr_in = ptr_ff - PTR_W'(1);
            end
         end
         OP_SIGN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               rsp_count_in = 16'd0;
               cnt_in       = cnt_inc;
            end
         end
         OP_DIGIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(cur_digit, is_upper);
               rsp_last_in  = (ptr_ff == '0);
               rsp_count_in = (ptr_ff == '0) ? cnt_inc : 16'd0;
               cnt_in       = cnt_inc;
               if (ptr_ff != '0) begin
                  ptr_in = ptr_ff - PTR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      cnt_ff       <= cnt_in;
      bits_ff      <= bits_in;
      ptr_ff       <= ptr_in;
      digit_ff     <= digit_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_count_out  = rsp_count_ff;

endmodule

[sv/ita_check.sv]
module ita_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_ascii_char,
   input logic        rsp_last,
   input logic [15:0] rsp_count_out
);
   import ita_pkg::*;

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii_char) &&
         $stable(rsp_last) && $stable(rsp_count_out))
      else $error("stalled response changed");

   // Leave reset with the output register empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Refuse a new request while a number is being worked on.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Carry the count on the final character only.
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_count_out == 16'd0)
      else $error("count on a non-final character");

   // Never end a number on the sign.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_ascii_char != ASCII_MINUS)
      else $error("number ended on a sign");

endmodule

bind integer_to_ascii_radix ita_check u_ita_check (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   import ita_pkg::*;

   // The package names no code for unsigned decimal; kinds 5 to 7 fall back to it too.
   localparam logic [2:0] KIND_UNSIGNED_DEC = 3'd1;

   // One character transaction on the response channel.
   typedef struct {
      logic [7:0]  ch;
      logic        last;
      logic [15:0] count;
   } char_item_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind     = '0;
   logic [63:0] req_value    = '0;
   logic [15:0] req_count_in = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [7:0]  rsp_ascii_char;
   logic        rsp_last;
   logic [15:0] rsp_count_out;

   // Characters still owed by the block, oldest first.
   char_item_type pending_chars [$];
   int unsigned   fail_count    = 0;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;

   integer_to_ascii_radix #(
      .VALUE_WIDTH (64)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_count_in   (req_count_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .rsp_count_out  (rsp_count_out)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the text of one number and queue its characters, sign first.
   function automatic void predict_text(logic [2:0] kind, logic [63:0] value,
                                        logic [15:0] count_in);
      logic [63:0]   magnitude;
      logic [63:0]   radix;
      logic          upper;
      logic          negative;
      logic [3:0]    digit;
      logic [7:0]    digits [$];
      logic [16:0]   total;
      char_item_type item;
      magnitude = value;
      radix     = 64'd10;
      upper     = 1'b0;
      negative  = 1'b0;
      case (kind)
         KIND_SIGNED_DEC: begin
            // Negate in full width, so the most negative value keeps its true magnitude.
            negative = value[63];
            if (negative) begin
               magnitude = ~value + 64'd1;
            end
         end
         KIND_OCTAL: begin
            radix = 64'd8;
         end
         KIND_HEX_LOWER: begin
            radix = 64'd16;
         end
         KIND_HEX_UPPER: begin
            radix = 64'd16;
            upper = 1'b1;
         end
         default: begin
            radix = 64'd10;
         end
      endcase
      // Peel digits from the bottom; zero still yields a single digit.
      do begin
         digit = 4'(magnitude % radix);
         if (digit < 4'd10) begin
            digits.push_front(ASCII_ZERO + 8'(digit));
         end else begin
            digits.push_front((upper ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(digit) - 8'd10);
         end
         magnitude = magnitude / radix;
      end while (magnitude != 64'd0);
      total = {1'b0, count_in} + 17'(digits.size()) + 17'(negative);
      if (total > {1'b0, COUNT_MAX}) begin
         total = {1'b0, COUNT_MAX};
      end
      if (negative) begin
         item.ch    = ASCII_MINUS;
         item.last  = 1'b0;
         item.count = 16'd0;
         pending_chars.push_back(item);
      end
      foreach (digits[i]) begin
         item.ch    = digits[i];
         item.last  = (i == digits.size() - 1);
         item.count = item.last ? total[15:0] : 16'd0;
         pending_chars.push_back(item);
      end
   endfunction

   // Offer one number, hold it until taken, then queue its characters.
   task automatic send_number(logic [2:0] kind, logic [63:0] value, logic [15:0] count_in);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_count_in <= count_in;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_text(kind, value, count_in);
   endtask

   // Random value of random length, so short and full-width numbers both turn up.
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0:       v = v >> $urandom_range(63);
         1:       v = v >> $urandom_range(48, 63);
         default: v = v;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] random_count();
      logic [15:0] c;
      c = 16'($urandom);
      // Land near the top now and then to hit saturation.
      if ($urandom_range(4) == 0) begin
         c = 16'hFFFF - 16'($urandom_range(24));
      end
      return c;
   endfunction

   function automatic logic [2:0] random_kind();
      logic [2:0] k;
      if ($urandom_range(9) == 0) begin
         k = 3'($urandom_range(5, 7));
      end else begin
         k = 3'($urandom_range(4));
      end
      return k;
   endfunction

   // Zero in every kind code, the unused ones included.
   task automatic test_zero_each_kind();
      for (int k = 0; k < 8; k++) begin
         send_number(3'(k), 64'd0, 16'd0);
      end
   endtask

   // Full-width patterns: longest texts, sign handling at both ends of the signed range.
   task automatic test_extremes();
      send_number(KIND_SIGNED_DEC,   64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
      send_number(KIND_UNSIGNED_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
      send_number(KIND_OCTAL,        64'hFFFF_FFFF_FFFF_FFFF, 16'd2);
      send_number(KIND_HEX_LOWER,    64'hFFFF_FFFF_FFFF_FFFF, 16'd3);
      send_number(KIND_HEX_UPPER,    64'hFFFF_FFFF_FFFF_FFFF, 16'd4);
      send_number(KIND_SIGNED_DEC,   64'h8000_0000_0000_0000, 16'd100);
      send_number(KIND_SIGNED_DEC,   64'h7FFF_FFFF_FFFF_FFFF, 16'd200);
      send_number(KIND_OCTAL,        64'h8000_0000_0000_0000, 16'd0);
   endtask

   // Every hex letter in both cases, and the digit-count boundaries.
   task automatic test_digits();
      send_number(KIND_HEX_LOWER,    64'h0123_4567_89AB_CDEF, 16'h5555);
      send_number(KIND_HEX_UPPER,    64'hFEDC_BA98_7654_3210, 16'hAAAA);
      send_number(KIND_UNSIGNED_DEC, 64'd9, 16'd0);
      send_number(KIND_SIGNED_DEC,   64'd10, 16'd0);
      send_number(KIND_OCTAL,        64'd8, 16'd0);
      send_number(KIND_SIGNED_DEC,   -64'sd1234567890, 16'd7);
   endtask

   // Drive the running count into and past its ceiling.
   task automatic test_count_saturation();
      send_number(KIND_UNSIGNED_DEC, 64'd5, 16'hFFFF);
      send_number(KIND_OCTAL,        64'hFFFF_FFFF_FFFF_FFFF, 16'hFFF0);
      send_number(KIND_SIGNED_DEC,   64'h8000_0000_0000_0000, 16'hFFEC);
   endtask

   task automatic test_random(int unsigned n);
      repeat (n) begin
         send_number(random_kind(), random_value(), random_count());
      end
   endtask

   // Take each character when not stalling and compare it with the oldest one owed.
   always @(posedge clock) begin : response_check
      char_item_type owed;
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char %h last %b count %h",
                     $time, rsp_ascii_char, rsp_last, rsp_count_out);
            fail_count++;
         end else begin
            owed = pending_chars.pop_front();
            if (rsp_ascii_char !== owed.ch) begin
               $display("%0t: ascii_char mismatch: expected %h, actual %h",
                        $time, owed.ch, rsp_ascii_char);
               fail_count++;
            end
            if (rsp_last !== owed.last) begin
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, owed.last, rsp_last);
               fail_count++;
            end
            if (rsp_count_out !== owed.count) begin
               $display("%0t: count_out mismatch: expected %h, actual %h",
                        $time, owed.count, rsp_count_out);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender mostly busy, receiver mostly stalling.
      send_gap_pct  = 18;
      rsp_stall_pct = 73;
      test_zero_each_kind();
      test_extremes();
      test_digits();
      test_count_saturation();
      test_random(52);

      // Swap the pressure: sender sparse, receiver eager.
      send_gap_pct  = 73;
      rsp_stall_pct = 18;
      test_random(52);

      // No idling on either side.
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random(52);

      req_valid <= 1'b0;

      // Drain, then keep watching for any stray character.
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (120) @(posedge clock);

      if (pending_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived, next expected %h",
                  $time, pending_chars.size(), pending_chars[0].ch);
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("integer_to_ascii_radix regression: pass");
      end else begin
         $display("integer_to_ascii_radix regression: fail");
      end
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("integer_to_ascii_radix regression: fail");
      $finish;
   end

endmodule

[sim.f]
sv/ita_pkg.sv
sv/ita_seq.sv
sv/integer_to_ascii_radix.sv
sv/ita_check.sv
dv/testbench.sv
